[hw/rtl/crp_pkg.sv]
package crp_pkg;

   // Register reset values
   localparam logic [19:0] FOCAL_X_RESET      = 20'd141921;
   localparam logic [19:0] FOCAL_Y_RESET      = 20'd141921;
   localparam logic [17:0] CENTER_X_RESET     = 18'd82048;
   localparam logic [17:0] CENTER_Y_RESET     = 18'd61568;
   localparam logic [23:0] PLANE_HEIGHT_RESET = 24'd0;

   // Smallest focal length the slope path accepts
   localparam logic [19:0] FOCAL_MIN = 20'd256;

   // Divider geometry
   localparam int SLOPE_NUM_W = 41;
   localparam int SLOPE_DEN_W = 25;
   localparam int SLOPE_QUO_W = 28;
   localparam int PT_NUM_W    = 62;
   localparam int PT_DEN_W    = 37;
   localparam int PT_QUO_W    = 26;

   localparam int DIV1_LAT   = SLOPE_QUO_W + 1;
   localparam int DIV2_LAT   = PT_QUO_W + 1;
   localparam int PIPE_DEPTH = DIV1_LAT + DIV2_LAT + 10;

   // Reduced ray direction keeps this many magnitude bits
   localparam int DIR_RED_W = 36;
   localparam int DIR_W     = 63;
   localparam int DIR_MAG_W = 62;

   typedef enum logic [1:0] {
      HIT_OK       = 2'd0,
      HIT_PARALLEL = 2'd1,
      HIT_BEHIND   = 2'd2
   } hit_status_type;

   typedef enum logic [2:0] {
      REG_FOCAL_X      = 3'd0,
      REG_FOCAL_Y      = 3'd1,
      REG_CENTER_X     = 3'd2,
      REG_CENTER_Y     = 3'd3,
      REG_PLANE_HEIGHT = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic signed [23:0] x;
      logic signed [23:0] y;
      logic signed [23:0] z;
   } cam_type;

   typedef struct packed {
      logic signed [15:0] qx;
      logic signed [15:0] qy;
      logic signed [15:0] qz;
      logic signed [15:0] qw;
      cam_type            cam;
      logic               neg_x;
   } slope_side_type;

   typedef struct packed {
      hit_status_type     status;
      logic               neg_x;
      logic               neg_y;
      logic signed [23:0] cam_x;
      logic signed [23:0] cam_y;
   } hit_side_type;

endpackage

[hw/rtl/crp_req_if.sv]
interface crp_req_if;
   logic               valid;
   logic               ready;
   logic [14:0]        obj_x;
   logic [14:0]        obj_y;
   logic signed [23:0] cam_x;
   logic signed [23:0] cam_y;
   logic signed [23:0] cam_z;
   logic signed [15:0] quat_x;
   logic signed [15:0] quat_y;
   logic signed [15:0] quat_z;
   logic signed [15:0] quat_w;

   modport source (
      output valid, obj_x, obj_y, cam_x, cam_y, cam_z, quat_x, quat_y, quat_z, quat_w,
      input  ready
   );
   modport sink (
      input  valid, obj_x, obj_y, cam_x, cam_y, cam_z, quat_x, quat_y, quat_z, quat_w,
      output ready
   );
endinterface

[hw/rtl/crp_rsp_if.sv]
interface crp_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         hit_status;
   logic signed [23:0] point_x;
   logic signed [23:0] point_y;
   logic signed [23:0] point_z;

   modport source (
      output valid, hit_status, point_x, point_y, point_z,
      input  ready
   );
   modport sink (
      input  valid, hit_status, point_x, point_y, point_z,
      output ready
   );
endinterface

[hw/rtl/camera_ray_plane_intersect_top.sv]
// Camera ray / table plane intersection.
// req_chan carries one detection per transaction: image position (1/64 mm from
// the top-left corner) and the camera pose (origin in Q3.20 m, quaternion in
// Q1.14). rsp_chan returns one transaction per request, in order: hit_status
// and the world point in Q3.20 m, saturated to 24 bits.
// Throughput: one transaction per cycle while rsp_chan does not stall. The pipeline has
// 66 register stages: the input capture, the slope dividers (29: operand register
// plus 28 quotient bits), eight datapath stages for rotation, ray scaling and the
// partial products, the intersection dividers (27: operand register plus 26
// quotient bits) and the output register.
// The whole pipeline advances on one enable; when rsp_chan stalls, every stage
// holds and req_chan.ready drops, so nothing is lost or repeated. Bubbles
// travel through as cleared valid bits.
// Configuration goes through the APB-style port, 4 bytes per register in the
// order focal_x, focal_y, center_x, center_y, plane_height. Write it only
// while the pipeline is empty.
// Reset (synchronous) clears all valid bits and loads the register defaults.
module camera_ray_plane_intersect_top
   import crp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   crp_req_if.sink     req_chan,
   crp_rsp_if.source   rsp_chan
);

   // ---------------------------------------------------------------- config
   logic [19:0]        focal_x_ff, focal_y_ff;
   logic [17:0]        center_x_ff, center_y_ff;
   logic signed [23:0] plane_h_ff;
   logic               cfg_wr;
   logic [19:0]        focal_x_eff, focal_y_eff;

   assign pready = 1'b1;
   assign cfg_wr = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_x_ff  <= FOCAL_X_RESET;
         focal_y_ff  <= FOCAL_Y_RESET;
         center_x_ff <= CENTER_X_RESET;
         center_y_ff <= CENTER_Y_RESET;
         plane_h_ff  <= PLANE_HEIGHT_RESET;
      end else if (cfg_wr) begin
         case (reg_index_type'(paddr[4:2]))
            REG_FOCAL_X:      focal_x_ff  <= pwdata[19:0];
            REG_FOCAL_Y:      focal_y_ff  <= pwdata[19:0];
            REG_CENTER_X:     center_x_ff <= pwdata[17:0];
            REG_CENTER_Y:     center_y_ff <= pwdata[17:0];
            REG_PLANE_HEIGHT: plane_h_ff  <= pwdata[23:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index_type'(paddr[4:2]))
         REG_FOCAL_X:      prdata = {12'd0, focal_x_ff};
         REG_FOCAL_Y:      prdata = {12'd0, focal_y_ff};
         REG_CENTER_X:     prdata = {14'd0, center_x_ff};
         REG_CENTER_Y:     prdata = {14'd0, center_y_ff};
         REG_PLANE_HEIGHT: prdata = {{8{plane_h_ff[23]}}, plane_h_ff};
         default:          prdata = '0;
      endcase
   end

   // Clamp tiny focal lengths
   assign focal_x_eff = (focal_x_ff < FOCAL_MIN) ? FOCAL_MIN : focal_x_ff;
   assign focal_y_eff = (focal_y_ff < FOCAL_MIN) ? FOCAL_MIN : focal_y_ff;

   // ------------------------------------------------------ pipeline control
   logic                  adv;
   logic [PIPE_DEPTH-1:0] vld_ff;

   assign adv            = !vld_ff[PIPE_DEPTH-1] || rsp_chan.ready;
   assign req_chan.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[PIPE_DEPTH-2:0], req_chan.valid};
      end
   end

   // ------------------------------------------------------ stage 0: capture
   logic [14:0]        ox_ff, oy_ff;
   cam_type            cam0_ff;
   logic signed [15:0] qx0_ff, qy0_ff, qz0_ff, qw0_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         ox_ff   <= req_chan.obj_x;
         oy_ff   <= req_chan.obj_y;
         cam0_ff <= '{x: req_chan.cam_x, y: req_chan.cam_y, z: req_chan.cam_z};
         qx0_ff  <= req_chan.quat_x;
         qy0_ff  <= req_chan.quat_y;
         qz0_ff  <= req_chan.quat_z;
         qw0_ff  <= req_chan.quat_w;
      end
   end

   // Slope numerators: u = 128*ox/15 - cx and v = -96*oy/11 - cy, scaled up by 15 and 11
   logic [21:0]            ox_scl, cx_scl, oy_scl, cy_scl;
   logic [21:0]            mag_sx;
   logic [22:0]            mag_sy;
   logic                   neg_sx;
   logic [23:0]            den_sx, den_sy;
   logic [SLOPE_NUM_W-1:0] div1_num_x, div1_num_y;

   always_comb begin
      ox_scl = {ox_ff, 7'd0};
      cx_scl = 22'(center_x_ff * 4'd15);
      oy_scl = 22'(oy_ff * 7'd96);
      cy_scl = 22'(center_y_ff * 4'd11);
      neg_sx = cx_scl > ox_scl;
      mag_sx = neg_sx ? cx_scl - ox_scl : ox_scl - cx_scl;
      mag_sy = 23'(oy_scl) + 23'(cy_scl);
      den_sx = 24'(focal_x_eff * 4'd15);
      den_sy = 24'(focal_y_eff * 4'd11);
      // Round to nearest: (2*a*2^16 + b) / (2*b)
      div1_num_x = SLOPE_NUM_W'({mag_sx, 17'd0}) + SLOPE_NUM_W'(den_sx);
      div1_num_y = SLOPE_NUM_W'({mag_sy, 17'd0}) + SLOPE_NUM_W'(den_sy);
   end

   logic [SLOPE_QUO_W-1:0] qmag_x, qmag_y;

   crp_div_pipe #(
      .NUM_W (SLOPE_NUM_W),
      .DEN_W (SLOPE_DEN_W),
      .QUO_W (SLOPE_QUO_W)
   ) u_div_slope_x (
      .clock (clock),
      .en    (adv),
      .num   (div1_num_x),
      .den   ({den_sx, 1'b0}),
      .quo   (qmag_x),
      .ovf   ()
   );

   crp_div_pipe #(
      .NUM_W (SLOPE_NUM_W),
      .DEN_W (SLOPE_DEN_W),
      .QUO_W (SLOPE_QUO_W)
   ) u_div_slope_y (
      .clock (clock),
      .en    (adv),
      .num   (div1_num_y),
      .den   ({den_sy, 1'b0}),
      .quo   (qmag_y),
      .ovf   ()
   );

   // Pose travels beside the slope dividers
   slope_side_type side1_ff [DIV1_LAT];

   always_ff @(posedge clock) begin
      if (adv) begin
         side1_ff[0] <= '{qx: qx0_ff, qy: qy0_ff, qz: qz0_ff, qw: qw0_ff,
                          cam: cam0_ff, neg_x: neg_sx};
         for (int i = 1; i < DIV1_LAT; i++) begin
            side1_ff[i] <= side1_ff[i-1];
         end
      end
   end

   // ------------------------------------- stage A: quaternion products
   slope_side_type     sa;
   logic signed [31:0] pxx_ff, pyy_ff, pzz_ff, pww_ff, pxy_ff;
   logic signed [31:0] pwz_ff, pxz_ff, pwy_ff, pyz_ff, pwx_ff;
   logic [SLOPE_QUO_W-1:0] qx_a_ff, qy_a_ff;
   logic               negx_a_ff;
   cam_type            cam_a_ff;

   assign sa = side1_ff[DIV1_LAT-1];

   always_ff @(posedge clock) begin
      if (adv) begin
         pxx_ff    <= sa.qx * sa.qx;
         pyy_ff    <= sa.qy * sa.qy;
         pzz_ff    <= sa.qz * sa.qz;
         pww_ff    <= sa.qw * sa.qw;
         pxy_ff    <= sa.qx * sa.qy;
         pwz_ff    <= sa.qw * sa.qz;
         pxz_ff    <= sa.qx * sa.qz;
         pwy_ff    <= sa.qw * sa.qy;
         pyz_ff    <= sa.qy * sa.qz;
         pwx_ff    <= sa.qw * sa.qx;
         qx_a_ff   <= qmag_x;
         qy_a_ff   <= qmag_y;
         negx_a_ff <= sa.neg_x;
         cam_a_ff  <= sa.cam;
      end
   end

   // ------------------------------------- stage B: rotation matrix, slopes
   logic signed [33:0] r00_ff, r01_ff, r02_ff, r10_ff, r11_ff, r12_ff;
   logic signed [33:0] r20_ff, r21_ff, r22_ff;
   logic signed [28:0] sx_ff, sy_ff;
   logic signed [28:0] sx_pos, sy_pos;
   cam_type            cam_b_ff;

   assign sx_pos = $signed({1'b0, qx_a_ff});
   assign sy_pos = $signed({1'b0, qy_a_ff});

   always_ff @(posedge clock) begin
      if (adv) begin
         r00_ff <= 34'(pww_ff) + 34'(pxx_ff) - 34'(pyy_ff) - 34'(pzz_ff);
         r11_ff <= 34'(pww_ff) - 34'(pxx_ff) + 34'(pyy_ff) - 34'(pzz_ff);
         r22_ff <= 34'(pww_ff) - 34'(pxx_ff) - 34'(pyy_ff) + 34'(pzz_ff);
         r01_ff <= (34'(pxy_ff) - 34'(pwz_ff)) <<< 1;
         r10_ff <= (34'(pxy_ff) + 34'(pwz_ff)) <<< 1;
         r02_ff <= (34'(pxz_ff) + 34'(pwy_ff)) <<< 1;
         r20_ff <= (34'(pxz_ff) - 34'(pwy_ff)) <<< 1;
         r12_ff <= (34'(pyz_ff) - 34'(pwx_ff)) <<< 1;
         r21_ff <= (34'(pyz_ff) + 34'(pwx_ff)) <<< 1;
         sx_ff  <= negx_a_ff ? -sx_pos : sx_pos;
         sy_ff  <= -sy_pos;
         cam_b_ff <= cam_a_ff;
      end
   end

   // ------------------------------------- stage C: matrix times slopes
   logic signed [DIR_W-1:0] m00_ff, m01_ff, m10_ff, m11_ff, m20_ff, m21_ff;
   logic signed [33:0]      r02_c_ff, r12_c_ff, r22_c_ff;
   cam_type                 cam_c_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         m00_ff   <= r00_ff * sx_ff;
         m01_ff   <= r01_ff * sy_ff;
         m10_ff   <= r10_ff * sx_ff;
         m11_ff   <= r11_ff * sy_ff;
         m20_ff   <= r20_ff * sx_ff;
         m21_ff   <= r21_ff * sy_ff;
         r02_c_ff <= r02_ff;
         r12_c_ff <= r12_ff;
         r22_c_ff <= r22_ff;
         cam_c_ff <= cam_b_ff;
      end
   end

   // ------------------------------------- stage D: ray direction
   logic signed [DIR_W-1:0] dx_ff, dy_ff, dz_ff;
   cam_type                 cam_d_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         dx_ff    <= m00_ff + m01_ff + (DIR_W'(r02_c_ff) <<< 16);
         dy_ff    <= m10_ff + m11_ff + (DIR_W'(r12_c_ff) <<< 16);
         dz_ff    <= m20_ff + m21_ff + (DIR_W'(r22_c_ff) <<< 16);
         cam_d_ff <= cam_c_ff;
      end
   end

   // ------------------------------------- stage E: magnitudes
   logic [DIR_MAG_W-1:0] magx_e_ff, magy_e_ff, magz_e_ff;
   logic                 sgx_e_ff, sgy_e_ff, sgz_e_ff;
   cam_type              cam_e_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         magx_e_ff <= DIR_MAG_W'(dx_ff[DIR_W-1] ? -dx_ff : dx_ff);
         magy_e_ff <= DIR_MAG_W'(dy_ff[DIR_W-1] ? -dy_ff : dy_ff);
         magz_e_ff <= DIR_MAG_W'(dz_ff[DIR_W-1] ? -dz_ff : dz_ff);
         sgx_e_ff  <= dx_ff[DIR_W-1];
         sgy_e_ff  <= dy_ff[DIR_W-1];
         sgz_e_ff  <= dz_ff[DIR_W-1];
         cam_e_ff  <= cam_d_ff;
      end
   end

   // ------------------------------------- stage F: reduction shift amount
   logic [DIR_MAG_W-1:0] mag_or;
   logic [4:0]           shamt;
   logic [4:0]           shamt_f_ff;
   logic [DIR_MAG_W-1:0] magx_f_ff, magy_f_ff, magz_f_ff;
   logic                 sgx_f_ff, sgy_f_ff, sgz_f_ff;
   cam_type              cam_f_ff;

   // The top set bit of the OR is the top set bit of the largest magnitude
   always_comb begin
      mag_or = magx_e_ff | magy_e_ff | magz_e_ff;
      shamt  = '0;
      for (int i = DIR_RED_W; i < DIR_MAG_W; i++) begin
         if (mag_or[i]) begin
            shamt = 5'(i - DIR_RED_W + 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         shamt_f_ff <= shamt;
         magx_f_ff  <= magx_e_ff;
         magy_f_ff  <= magy_e_ff;
         magz_f_ff  <= magz_e_ff;
         sgx_f_ff   <= sgx_e_ff;
         sgy_f_ff   <= sgy_e_ff;
         sgz_f_ff   <= sgz_e_ff;
         cam_f_ff   <= cam_e_ff;
      end
   end

   // ------------------------------------- stage G: truncate toward zero
   logic [DIR_RED_W-1:0] dxr_ff, dyr_ff, dzr_ff;
   logic                 sgx_g_ff, sgy_g_ff, sgz_g_ff;
   cam_type              cam_g_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         dxr_ff   <= DIR_RED_W'(magx_f_ff >> shamt_f_ff);
         dyr_ff   <= DIR_RED_W'(magy_f_ff >> shamt_f_ff);
         dzr_ff   <= DIR_RED_W'(magz_f_ff >> shamt_f_ff);
         sgx_g_ff <= sgx_f_ff;
         sgy_g_ff <= sgy_f_ff;
         sgz_g_ff <= sgz_f_ff;
         cam_g_ff <= cam_f_ff;
      end
   end

   // ------------------------------------- stage H: height, partial products
   logic signed [24:0] dh;
   logic [23:0]        dh_mag;
   logic               dh_neg;
   hit_status_type     status_h;
   logic [41:0]        pxl_ff, pxh_ff, pyl_ff, pyh_ff;
   logic [DIR_RED_W-1:0] dzm_ff;
   hit_side_type       side_h_ff;

   always_comb begin
      dh     = 25'(plane_h_ff) - 25'(cam_g_ff.z);
      dh_neg = dh[24];
      dh_mag = 24'(dh_neg ? -dh : dh);
      if (dzr_ff == '0) begin
         status_h = HIT_PARALLEL;
      end else if (dh == '0 || dh_neg != sgz_g_ff) begin
         status_h = HIT_BEHIND;
      end else begin
         status_h = HIT_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pxl_ff    <= dh_mag * dxr_ff[17:0];
         pxh_ff    <= dh_mag * dxr_ff[35:18];
         pyl_ff    <= dh_mag * dyr_ff[17:0];
         pyh_ff    <= dh_mag * dyr_ff[35:18];
         dzm_ff    <= dzr_ff;
         side_h_ff <= '{status: status_h,
                        neg_x: dh_neg ^ sgx_g_ff ^ sgz_g_ff,
                        neg_y: dh_neg ^ sgy_g_ff ^ sgz_g_ff,
                        cam_x: cam_g_ff.x, cam_y: cam_g_ff.y};
      end
   end

   // ------------------------------------- intersection dividers
   logic [59:0]         ax, ay;
   logic [PT_NUM_W-1:0] div2_num_x, div2_num_y;
   logic [PT_DEN_W-1:0] div2_den;

   always_comb begin
      ax = 60'(pxl_ff) + {pxh_ff, 18'd0};
      ay = 60'(pyl_ff) + {pyh_ff, 18'd0};
      div2_num_x = PT_NUM_W'({ax, 1'b0}) + PT_NUM_W'(dzm_ff);
      div2_num_y = PT_NUM_W'({ay, 1'b0}) + PT_NUM_W'(dzm_ff);
      div2_den   = {dzm_ff, 1'b0};
   end

   logic [PT_QUO_W-1:0] tq_x, tq_y;
   logic                tovf_x, tovf_y;

   crp_div_pipe #(
      .NUM_W (PT_NUM_W),
      .DEN_W (PT_DEN_W),
      .QUO_W (PT_QUO_W)
   ) u_div_point_x (
      .clock (clock),
      .en    (adv),
      .num   (div2_num_x),
      .den   (div2_den),
      .quo   (tq_x),
      .ovf   (tovf_x)
   );

   crp_div_pipe #(
      .NUM_W (PT_NUM_W),
      .DEN_W (PT_DEN_W),
      .QUO_W (PT_QUO_W)
   ) u_div_point_y (
      .clock (clock),
      .en    (adv),
      .num   (div2_num_y),
      .den   (div2_den),
      .quo   (tq_y),
      .ovf   (tovf_y)
   );

   hit_side_type side2_ff [DIV2_LAT];

   always_ff @(posedge clock) begin
      if (adv) begin
         side2_ff[0] <= side_h_ff;
         for (int i = 1; i < DIV2_LAT; i++) begin
            side2_ff[i] <= side2_ff[i-1];
         end
      end
   end

   // ------------------------------------- output: offset and saturate
   function automatic logic signed [23:0] sat_point(
      input logic signed [23:0]  cam,
      input logic [PT_QUO_W-1:0] q,
      input logic                neg,
      input logic                ovf
   );
      logic signed [27:0] q_pos;
      logic signed [27:0] sum;
      logic signed [23:0] res;
      q_pos = $signed({2'b00, q});
      sum   = 28'(cam) + (neg ? -q_pos : q_pos);
      if (ovf) begin
         res = neg ? 24'sh800000 : 24'sh7FFFFF;
      end else if (sum > 28'sh07FFFFF) begin
         res = 24'sh7FFFFF;
      end else if (sum < -28'sh0800000) begin
         res = 24'sh800000;
      end else begin
         res = sum[23:0];
      end
      return res;
   endfunction

   hit_side_type       so;
   hit_status_type     out_status_ff;
   logic signed [23:0] out_x_ff, out_y_ff, out_z_ff;

   assign so = side2_ff[DIV2_LAT-1];

   always_ff @(posedge clock) begin
      if (adv) begin
         out_status_ff <= so.status;
         if (so.status == HIT_OK) begin
            out_x_ff <= sat_point(so.cam_x, tq_x, so.neg_x, tovf_x);
            out_y_ff <= sat_point(so.cam_y, tq_y, so.neg_y, tovf_y);
            out_z_ff <= plane_h_ff;
         end else begin
            out_x_ff <= '0;
            out_y_ff <= '0;
            out_z_ff <= '0;
         end
      end
   end

   assign rsp_chan.valid      = vld_ff[PIPE_DEPTH-1];
   assign rsp_chan.hit_status = out_status_ff;
   assign rsp_chan.point_x    = out_x_ff;
   assign rsp_chan.point_y    = out_y_ff;
   assign rsp_chan.point_z    = out_z_ff;

   // ------------------------------------- assertions
   a_fail_zero_point: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && out_status_ff != HIT_OK |->
         rsp_chan.point_x == '0 && rsp_chan.point_y == '0 && rsp_chan.point_z == '0)
      else $error("failed hit carries a nonzero point");

   a_ok_on_plane: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && out_status_ff == HIT_OK |-> rsp_chan.point_z == plane_h_ff)
      else $error("hit point is off the plane");

   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff))
      else $error("pipeline moved during a stall");

endmodule

[hw/rtl/crp_div_pipe.sv]
// Pipelined restoring divider, one quotient bit per stage.
// quo = num / den for quotients below 2**QUO_W; ovf flags larger ones.
module crp_div_pipe #(
   parameter int NUM_W = 41,
   parameter int DEN_W = 25,
   parameter int QUO_W = 28
) (
   input  logic             clock,
   input  logic             en,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [QUO_W-1:0] quo,
   output logic             ovf
);
   localparam int WORK_W = ((NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W) + 1;

   logic [WORK_W-1:0] rem_ff [QUO_W+1];
   logic [DEN_W-1:0]  den_ff [QUO_W+1];
   logic [QUO_W-1:0]  quo_ff [QUO_W+1];
   logic              ovf_ff [QUO_W+1];

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= WORK_W'(num);
         den_ff[0] <= den;
         quo_ff[0] <= '0;
         ovf_ff[0] <= WORK_W'(num) >= (WORK_W'(den) << QUO_W);
      end
   end

   for (genvar j = 1; j <= QUO_W; j++) begin : g_step
      localparam int BIT = QUO_W - j;
      logic [WORK_W-1:0] trial;
      logic              fits;
      logic [WORK_W-1:0] rem_in;
      logic [QUO_W-1:0]  quo_in;

      always_comb begin
         trial  = WORK_W'(den_ff[j-1]) << BIT;
         fits   = rem_ff[j-1] >= trial;
         rem_in = fits ? rem_ff[j-1] - trial : rem_ff[j-1];
         quo_in = quo_ff[j-1];
         quo_in[BIT] = fits;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j] <= rem_in;
            den_ff[j] <= den_ff[j-1];
            quo_ff[j] <= quo_in;
            ovf_ff[j] <= ovf_ff[j-1];
         end
      end
   end

   assign quo = quo_ff[QUO_W];
   assign ovf = ovf_ff[QUO_W];
endmodule

[sim/tb_camera_ray_plane_intersect_top.sv]
module tb_camera_ray_plane_intersect_top
   import crp_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY = 66;

   // One expected point per accepted request
   typedef struct {
      logic [1:0]         status;
      logic signed [23:0] px;
      logic signed [23:0] py;
      logic signed [23:0] pz;
   } point_type;

   logic        clock;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [4:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   crp_req_if req_chan ();
   crp_rsp_if rsp_chan ();

   camera_ray_plane_intersect_top dut (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .req_chan (req_chan.source),
      .rsp_chan (rsp_chan.sink)
   );

   // Shadow copy of the camera and plane registers
   logic [19:0]        shadow_focal_x;
   logic [19:0]        shadow_focal_y;
   logic [17:0]        shadow_center_x;
   logic [17:0]        shadow_center_y;
   logic signed [23:0] shadow_plane;

   point_type expected_points[$];
   int        error_count;
   int        send_idle_pct;
   int        recv_stall_pct;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hold the run to a generous ceiling; a hung handshake ends here
   initial begin
      #20ms;
      $display("[FAIL] regression broken");
      $finish;
   end

   // Magnitude and rounding helpers; ties go away from zero
   function automatic longint unsigned magnitude(input longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic longint divide_rounded(input longint n, input longint d);
      longint unsigned a, b, q;
      logic            neg;
      neg = (n < 0) != (d < 0);
      a   = magnitude(n);
      b   = magnitude(d);
      q   = (2 * a + b) / (2 * b);
      return neg ? -longint'(q) : longint'(q);
   endfunction

   function automatic logic signed [23:0] clamp_q320(input longint v);
      if (v > 64'sd8388607) return 24'sh7fffff;
      if (v < -64'sd8388608) return 24'sh800000;
      return v[23:0];
   endfunction

   // Back-project the image position, rotate the ray, intersect with z = plane
   function automatic point_type predict_point(
      input logic [14:0] ox, input logic [14:0] oy,
      input logic signed [23:0] cx, input logic signed [23:0] cy,
      input logic signed [23:0] cz,
      input logic signed [15:0] qx, input logic signed [15:0] qy,
      input logic signed [15:0] qz, input logic signed [15:0] qw);
      point_type   p;
      longint      fx, fy, sx, sy, sz;
      longint      r00, r01, r02, r10, r11, r12, r20, r21, r22;
      longint      dx, dy, dz, dh, h, lqx, lqy, lqz, lqw;
      longint unsigned mx;
      int          s;
      fx  = (shadow_focal_x < FOCAL_MIN) ? 256 : longint'(shadow_focal_x);
      fy  = (shadow_focal_y < FOCAL_MIN) ? 256 : longint'(shadow_focal_y);
      lqx = qx;
      lqy = qy;
      lqz = qz;
      lqw = qw;
      h   = shadow_plane;
      sz  = 65536;
      sx  = divide_rounded((128 * longint'(ox) - 15 * longint'(shadow_center_x)) * 65536,
                           15 * fx);
      sy  = divide_rounded((-96 * longint'(oy) - 11 * longint'(shadow_center_y)) * 65536,
                           11 * fy);
      r00 = lqw*lqw + lqx*lqx - lqy*lqy - lqz*lqz;
      r11 = lqw*lqw - lqx*lqx + lqy*lqy - lqz*lqz;
      r22 = lqw*lqw - lqx*lqx - lqy*lqy + lqz*lqz;
      r01 = 2 * (lqx*lqy - lqw*lqz);
      r10 = 2 * (lqx*lqy + lqw*lqz);
      r02 = 2 * (lqx*lqz + lqw*lqy);
      r20 = 2 * (lqx*lqz - lqw*lqy);
      r12 = 2 * (lqy*lqz - lqw*lqx);
      r21 = 2 * (lqy*lqz + lqw*lqx);
      dx  = r00*sx + r01*sy + r02*sz;
      dy  = r10*sx + r11*sy + r12*sz;
      dz  = r20*sx + r21*sy + r22*sz;
      // Reduce the direction to 36 magnitude bits, truncating toward zero
      mx = magnitude(dx);
      if (magnitude(dy) > mx) mx = magnitude(dy);
      if (magnitude(dz) > mx) mx = magnitude(dz);
      s = 0;
      while ((mx >> s) >= (64'd1 << 36) && s < 63) s++;
      dx = dx < 0 ? -longint'(magnitude(dx) >> s) : longint'(magnitude(dx) >> s);
      dy = dy < 0 ? -longint'(magnitude(dy) >> s) : longint'(magnitude(dy) >> s);
      dz = dz < 0 ? -longint'(magnitude(dz) >> s) : longint'(magnitude(dz) >> s);
      dh = h - longint'(cz);
      p.px = '0;
      p.py = '0;
      p.pz = '0;
      if (dz == 0) begin
         p.status = HIT_PARALLEL;
      end else if (dh == 0 || ((dh < 0) != (dz < 0))) begin
         p.status = HIT_BEHIND;
      end else begin
         p.status = HIT_OK;
         p.px = clamp_q320(longint'(cx) + divide_rounded(dh * dx, dz));
         p.py = clamp_q320(longint'(cy) + divide_rounded(dh * dy, dz));
         p.pz = clamp_q320(h);
      end
      return p;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // Drive the sink side: random stall and compare each transaction in order
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_points.size() == 0) begin
               report_mismatch("unexpected transaction", 1, 0);
            end else begin
               point_type want;
               want = expected_points.pop_front();
               if (rsp_chan.hit_status !== want.status)
                  report_mismatch("hit_status", rsp_chan.hit_status, want.status);
               if (rsp_chan.point_x !== want.px)
                  report_mismatch("point_x", rsp_chan.point_x, want.px);
               if (rsp_chan.point_y !== want.py)
                  report_mismatch("point_y", rsp_chan.point_y, want.py);
               if (rsp_chan.point_z !== want.pz)
                  report_mismatch("point_z", rsp_chan.point_z, want.pz);
            end
         end
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Write one register through a setup and an access cycle; keep the shadow in step
   task automatic write_register(input reg_index_type idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         REG_FOCAL_X:      shadow_focal_x  = value[19:0];
         REG_FOCAL_Y:      shadow_focal_y  = value[19:0];
         REG_CENTER_X:     shadow_center_x = value[17:0];
         REG_CENTER_Y:     shadow_center_y = value[17:0];
         REG_PLANE_HEIGHT: shadow_plane    = value[23:0];
         default: ;
      endcase
   endtask

   task automatic configure(input logic [19:0] fx, input logic [19:0] fy,
                            input logic [17:0] cx, input logic [17:0] cy,
                            input logic [23:0] h);
      write_register(REG_FOCAL_X, {12'd0, fx});
      write_register(REG_FOCAL_Y, {12'd0, fy});
      write_register(REG_CENTER_X, {14'd0, cx});
      write_register(REG_CENTER_Y, {14'd0, cy});
      write_register(REG_PLANE_HEIGHT, {8'd0, h});
   endtask

   // Drain every outstanding transaction, then let the pipeline settle
   task automatic drain_pipeline();
      while (expected_points.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   // Send one request; record its prediction at the accepting edge
   task automatic send_detection(
      input logic [14:0] ox, input logic [14:0] oy,
      input logic [23:0] cx, input logic [23:0] cy, input logic [23:0] cz,
      input logic [15:0] qx, input logic [15:0] qy,
      input logic [15:0] qz, input logic [15:0] qw);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid  <= 1'b1;
      req_chan.obj_x  <= ox;
      req_chan.obj_y  <= oy;
      req_chan.cam_x  <= cx;
      req_chan.cam_y  <= cy;
      req_chan.cam_z  <= cz;
      req_chan.quat_x <= qx;
      req_chan.quat_y <= qy;
      req_chan.quat_z <= qz;
      req_chan.quat_w <= qw;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      expected_points.push_back(predict_point(ox, oy, cx, cy, cz, qx, qy, qz, qw));
      // Leave valid high; an idle cycle in the next call or idle_sender lowers it
   endtask

   task automatic idle_sender();
      req_chan.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Quaternion one in Q1.14; as qx it turns the camera 180 degrees about x to look straight down
   localparam logic [15:0] Q_ONE  = 16'sd16384;

   task automatic test_directed_cases();
      // Identity pose, camera below the reset plane: the image corners, then an inner point
      send_detection(15'd0, 15'd0, 24'd0, 24'd0, -24'sd1048576, 0, 0, 0, Q_ONE);
      send_detection(15'h7fff, 15'h7fff, 24'h7fffff, 24'h800000, -24'sd1048576,
                     0, 0, 0, Q_ONE);
      send_detection(15'd19200, 15'd14080, 24'd5, -24'sd7, 24'h800000, 0, 0, 0, Q_ONE);
      // Looking down from above the plane
      send_detection(15'd9600, 15'd7040, 24'd100, 24'd200, 24'sd2097152, Q_ONE, 0, 0, 0);
      send_detection(15'd1234, 15'd4321, 24'h7fffff, 24'h7fffff, 24'h7fffff,
                     Q_ONE, 0, 0, 0);
      // Behind camera: zero height difference, then opposite sign
      send_detection(15'd500, 15'd500, 24'd0, 24'd0, 24'd0, 0, 0, 0, Q_ONE);
      send_detection(15'd500, 15'd500, 24'd0, 24'd0, 24'sd1048576, 0, 0, 0, Q_ONE);
      // Parallel: all-zero quaternion, and a quarter turn about x on the top image row
      send_detection(15'd100, 15'd200, 24'd0, 24'd0, -24'sd5, 0, 0, 0, 0);
      send_detection(15'd0, 15'd0, 24'd0, 24'd0, -24'sd5, 16'sd11585, 0, 0, 16'sd11585);
      // Quaternion extremes including the out-of-range negative code
      send_detection(15'd3000, 15'd3000, 24'd1, 24'd2, -24'sd3, 16'h8000, 16'h8000,
                     16'h8000, 16'h8000);
      send_detection(15'd3000, 15'd3000, 24'd1, 24'd2, 24'sd3, 16'h7fff, 16'h8001,
                     16'h4000, 16'hc000);
      send_detection(15'd7, 15'd9, 24'h800000, 24'h7fffff, 24'h7fffff, 16'hffff,
                     16'hffff, 16'hffff, 16'hffff);
      // Far oblique ray from the extremes: saturates
      send_detection(15'h7fff, 15'd0, 24'h7ffff0, 24'h800010, 24'h800000, 16'sd2000,
                     16'sd100, 16'sd16000, 16'sd300);
      idle_sender();
   endtask

   task automatic random_detection();
      logic [15:0] qx, qy, qz, qw;
      logic [23:0] cz;
      int          mode;
      mode = $urandom_range(9);
      if (mode < 7) begin
         // Plausible pose: qx anywhere in [-1, 1], small qy, qz and qw, modest height
         qx = 16'(int'($urandom_range(32768)) - 16384);
         qy = 16'(int'($urandom_range(8000)) - 4000);
         qz = 16'(int'($urandom_range(8000)) - 4000);
         qw = 16'(int'($urandom_range(8000)) - 4000);
         cz = 24'(int'($urandom_range(4194304)) - 2097152);
      end else begin
         qx = 16'($urandom);
         qy = 16'($urandom);
         qz = 16'($urandom);
         qw = 16'($urandom);
         cz = 24'($urandom);
      end
      send_detection(15'($urandom), 15'($urandom), 24'($urandom), 24'($urandom), cz,
                     qx, qy, qz, qw);
   endtask

   task automatic test_random_phase(input int idle_pct, input int stall_pct, input int count);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (count) random_detection();
      idle_sender();
   endtask

   initial begin
      error_count     = 0;
      send_idle_pct   = 0;
      recv_stall_pct  = 0;
      reset           = 1'b1;
      psel            = 1'b0;
      penable         = 1'b0;
      pwrite          = 1'b0;
      paddr           = '0;
      pwdata          = '0;
      req_chan.valid  = 1'b0;
      req_chan.obj_x  = '0;
      req_chan.obj_y  = '0;
      req_chan.cam_x  = '0;
      req_chan.cam_y  = '0;
      req_chan.cam_z  = '0;
      req_chan.quat_x = '0;
      req_chan.quat_y = '0;
      req_chan.quat_z = '0;
      req_chan.quat_w = '0;
      shadow_focal_x  = FOCAL_X_RESET;
      shadow_focal_y  = FOCAL_Y_RESET;
      shadow_center_x = CENTER_X_RESET;
      shadow_center_y = CENTER_Y_RESET;
      shadow_plane    = PLANE_HEIGHT_RESET;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset register values first
      test_directed_cases();
      drain_pipeline();
      test_random_phase(0, 0, 120);
      drain_pipeline();

      // Minimum focal, zero centre, plane at the bottom of the range
      configure(20'd0, 20'd255, 18'd0, 18'd0, 24'h800000);
      test_directed_cases();
      test_random_phase(85, 0, 110);
      drain_pipeline();

      // Maximum focal and centre, top plane
      configure(20'hfffff, 20'hfffff, 18'h3ffff, 18'h3ffff, 24'h7fffff);
      test_random_phase(0, 85, 110);
      // Hold off sending until every transaction has come back
      while (expected_points.size() != 0) @(posedge clock);
      test_random_phase(8, 8, 60);
      drain_pipeline();

      // Random mid-range settings
      configure(20'($urandom_range(300000, 256)), 20'($urandom_range(300000, 256)),
                18'($urandom), 18'($urandom),
                24'(int'($urandom_range(2097152)) - 1048576));
      test_random_phase(8, 8, 120);
      test_random_phase(0, 0, 80);

      drain_pipeline();
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
